[hw/rtl/vrp_pkg.sv]
package vrp_pkg;

    // fixed formats: coordinates Q16.16, trig values Q2.14
    localparam int COORD_W        = 32;
    localparam int TRIG_W         = 16;
    localparam int TRIG_FRAC_BITS = 14;

    // one product, the sum of two products, and the rounded sum
    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - TRIG_FRAC_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RND_W-1:0]   rnd_t;

    localparam acc_t ROUND_HALF = ACC_W'(2 ** (TRIG_FRAC_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_Z = 3'd0,
        CFG_SIN_Z = 3'd1,
        CFG_COS_Y = 3'd2,
        CFG_SIN_Y = 3'd3,
        CFG_COS_X = 3'd4,
        CFG_SIN_X = 3'd5
    } cfg_reg_t;

    localparam trig_t COS_Z_RESET = 16'sd16322;
    localparam trig_t SIN_Z_RESET = 16'sd1428;
    localparam trig_t COS_Y_RESET = 16'sd16384;
    localparam trig_t SIN_Y_RESET = 16'sd0;
    localparam trig_t COS_X_RESET = 16'sd16384;
    localparam trig_t SIN_X_RESET = 16'sd0;

    typedef struct packed {
        trig_t cos_z;
        trig_t sin_z;
        trig_t cos_y;
        trig_t sin_y;
        trig_t cos_x;
        trig_t sin_x;
    } trig_set_t;

    // one vertex in flight: working coordinates, pivot, clip flag
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   sat;
    } vtx_item_t;

    typedef struct packed {
        logic   sat;
        coord_t v;
    } sat_coord_t;

    // saturate a 33-bit sum or difference to 32 bits
    function automatic sat_coord_t clip33(input logic signed [COORD_W:0] a);
        sat_coord_t r;
        r.sat = (a[COORD_W] != a[COORD_W-1]);
        if (r.sat)
        begin
            r.v = a[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r.v = a[COORD_W-1:0];
        end
        return r;
    endfunction

    // saturate a rounded rotation sum to 32 bits
    function automatic sat_coord_t clip_rnd(input rnd_t a);
        sat_coord_t r;
        logic [RND_W-COORD_W:0] upper;
        upper = a[RND_W-1:COORD_W-1];
        r.sat = !((&upper) || (~|upper));
        if (r.sat)
        begin
            r.v = a[RND_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r.v = a[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/vertex_rotate_about_pivot.sv]
// an accepted beat passes the queue, the pipeline stages and the output register
// throughput: one vertex per cycle while not stalled; three two-stage rotation
// units and the output register are fully pipelined, twelve 32x16 multipliers in all
// reset: queue emptied, pipeline and output valids cleared, trig registers set to
// a five degree rotation about z and none about y and x
module vertex_rotate_about_pivot (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  vrp_pkg::trig_t                 cfg_data,
    // vertex input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  vrp_pkg::coord_t                vertex_x,
    input  vrp_pkg::coord_t                vertex_y,
    input  vrp_pkg::coord_t                vertex_z,
    input  vrp_pkg::coord_t                pivot_x,
    input  vrp_pkg::coord_t                pivot_y,
    input  vrp_pkg::coord_t                pivot_z,
    // rotated vertex output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output vrp_pkg::coord_t                rotated_x,
    output vrp_pkg::coord_t                rotated_y,
    output vrp_pkg::coord_t                rotated_z,
    output logic                           saturated_flag
);
    import vrp_pkg::*;

    trig_set_t trig_reg;
    vtx_item_t q_item;
    vtx_item_t q_head;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    // user must change registers only while the datapath is idle; no check, no stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg.cos_z <= COS_Z_RESET;
            trig_reg.sin_z <= SIN_Z_RESET;
            trig_reg.cos_y <= COS_Y_RESET;
            trig_reg.sin_y <= SIN_Y_RESET;
            trig_reg.cos_x <= COS_X_RESET;
            trig_reg.sin_x <= SIN_X_RESET;
        end
        else if (cfg_valid)
        begin
            // unknown index: write dropped
            case (cfg_reg_t'(cfg_index))
                CFG_COS_Z: trig_reg.cos_z <= cfg_data;
                CFG_SIN_Z: trig_reg.sin_z <= cfg_data;
                CFG_COS_Y: trig_reg.cos_y <= cfg_data;
                CFG_SIN_Y: trig_reg.sin_y <= cfg_data;
                CFG_COS_X: trig_reg.cos_x <= cfg_data;
                CFG_SIN_X: trig_reg.sin_x <= cfg_data;
                default:   trig_reg <= trig_reg;
            endcase
        end
    end

    // front: take a beat, subtract the pivot, saturate
    vrp_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .vertex_z (vertex_z),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .pivot_z  (pivot_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    // short queue so input and output stalls stay decoupled
    vrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: rotate z, y, x, add the pivot back, hold the result beat
    vrp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .trig           (trig_reg),
        .head           (q_head),
        .head_valid     (!q_empty),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rotated_x      (rotated_x),
        .rotated_y      (rotated_y),
        .rotated_z      (rotated_z),
        .saturated_flag (saturated_flag)
    );

endmodule

[hw/rtl/vrp_front.sv]
module vrp_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  vrp_pkg::coord_t    vertex_x,
    input  vrp_pkg::coord_t    vertex_y,
    input  vrp_pkg::coord_t    vertex_z,
    input  vrp_pkg::coord_t    pivot_x,
    input  vrp_pkg::coord_t    pivot_y,
    input  vrp_pkg::coord_t    pivot_z,
    input  logic               q_full,
    output logic               q_push,
    output vrp_pkg::vtx_item_t q_item
);
    import vrp_pkg::*;

    sat_coord_t dx;
    sat_coord_t dy;
    sat_coord_t dz;

    // move the vertex into pivot-relative coordinates
    always_comb
    begin
        dx = clip33((COORD_W + 1)'(vertex_x) - (COORD_W + 1)'(pivot_x));
        dy = clip33((COORD_W + 1)'(vertex_y) - (COORD_W + 1)'(pivot_y));
        dz = clip33((COORD_W + 1)'(vertex_z) - (COORD_W + 1)'(pivot_z));
        q_item.x   = dx.v;
        q_item.y   = dy.v;
        q_item.z   = dz.v;
        q_item.px  = pivot_x;
        q_item.py  = pivot_y;
        q_item.pz  = pivot_z;
        q_item.sat = dx.sat | dy.sat | dz.sat;
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

[hw/rtl/vrp_queue.sv]
module vrp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vrp_pkg::vtx_item_t push_item,
    input  logic               pop,
    output vrp_pkg::vtx_item_t head,
    output logic               full,
    output logic               empty
);
    import vrp_pkg::*;

    vtx_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hw/rtl/vrp_rot.sv]
module vrp_rot (
    input  logic            clk,
    input  logic            en,
    input  vrp_pkg::coord_t p,
    input  vrp_pkg::coord_t q,
    input  vrp_pkg::trig_t  c,
    input  vrp_pkg::trig_t  s,
    output vrp_pkg::coord_t u,
    output vrp_pkg::coord_t w,
    output logic            sat
);
    import vrp_pkg::*;

    // u = p*c - q*s, w = p*s + q*c, rounded and saturated
    logic signed [PROD_W-1:0] pc_reg;
    logic signed [PROD_W-1:0] qs_reg;
    logic signed [PROD_W-1:0] ps_reg;
    logic signed [PROD_W-1:0] qc_reg;
    acc_t       u_acc;
    acc_t       w_acc;
    sat_coord_t u_clip;
    sat_coord_t w_clip;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg <= p * c;
            qs_reg <= q * s;
            ps_reg <= p * s;
            qc_reg <= q * c;
        end
    end

    always_comb
    begin
        u_acc  = ACC_W'(pc_reg) - ACC_W'(qs_reg) + ROUND_HALF;
        w_acc  = ACC_W'(ps_reg) + ACC_W'(qc_reg) + ROUND_HALF;
        u_clip = clip_rnd(u_acc[ACC_W-1:TRIG_FRAC_BITS]);
        w_clip = clip_rnd(w_acc[ACC_W-1:TRIG_FRAC_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u   <= u_clip.v;
            w   <= w_clip.v;
            sat <= u_clip.sat | w_clip.sat;
        end
    end

endmodule

[hw/rtl/vrp_back.sv]
module vrp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  vrp_pkg::trig_set_t trig,
    input  vrp_pkg::vtx_item_t head,
    input  logic               head_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output vrp_pkg::coord_t    rotated_x,
    output vrp_pkg::coord_t    rotated_y,
    output vrp_pkg::coord_t    rotated_z,
    output logic               saturated_flag
);
    import vrp_pkg::*;

    localparam int STAGES = 6;

    vtx_item_t          pipe_reg [STAGES];
    logic [STAGES-1:0]  valid_reg;
    logic               en;

    coord_t     zu, zw, yu, yw, xu, xw;
    logic       zs, ys, xs;
    vtx_item_t  eff1, eff3, eff5;
    sat_coord_t fx, fy, fz;

    // whole pipeline moves together unless the output beat is stalled
    assign en  = !out_valid || out_ready;
    assign pop = en && head_valid;

    // about z: (x, y)
    vrp_rot u_rot_z (
        .clk (clk), .en (en),
        .p (head.x), .q (head.y), .c (trig.cos_z), .s (trig.sin_z),
        .u (zu), .w (zw), .sat (zs)
    );

    // about y: (z, x)
    vrp_rot u_rot_y (
        .clk (clk), .en (en),
        .p (eff1.z), .q (eff1.x), .c (trig.cos_y), .s (trig.sin_y),
        .u (yu), .w (yw), .sat (ys)
    );

    // about x: (y, z)
    vrp_rot u_rot_x (
        .clk (clk), .en (en),
        .p (eff3.y), .q (eff3.z), .c (trig.cos_x), .s (trig.sin_x),
        .u (xu), .w (xw), .sat (xs)
    );

    always_comb
    begin
        eff1     = pipe_reg[1];
        eff1.x   = zu;
        eff1.y   = zw;
        eff1.sat = pipe_reg[1].sat | zs;

        eff3     = pipe_reg[3];
        eff3.z   = yu;
        eff3.x   = yw;
        eff3.sat = pipe_reg[3].sat | ys;

        eff5     = pipe_reg[5];
        eff5.y   = xu;
        eff5.z   = xw;
        eff5.sat = pipe_reg[5].sat | xs;

        fx = clip33((COORD_W + 1)'(eff5.x) + (COORD_W + 1)'(eff5.px));
        fy = clip33((COORD_W + 1)'(eff5.y) + (COORD_W + 1)'(eff5.py));
        fz = clip33((COORD_W + 1)'(eff5.z) + (COORD_W + 1)'(eff5.pz));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= head;
            pipe_reg[1] <= pipe_reg[0];
            pipe_reg[2] <= eff1;
            pipe_reg[3] <= pipe_reg[2];
            pipe_reg[4] <= eff3;
            pipe_reg[5] <= pipe_reg[4];
            rotated_x      <= fx.v;
            rotated_y      <= fy.v;
            rotated_z      <= fz.v;
            saturated_flag <= eff5.sat | fx.sat | fy.sat | fz.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], head_valid};
            out_valid <= valid_reg[STAGES-1];
        end
    end

endmodule

[hw/rtl/vrp_checker.sv]
module vrp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input vrp_pkg::coord_t                rotated_x,
    input vrp_pkg::coord_t                rotated_y,
    input vrp_pkg::coord_t                rotated_z,
    input logic                           saturated_flag
);
    import vrp_pkg::*;

    // queue entries plus six pipeline stages plus the output register
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 7;
    localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            case ({in_beat, out_beat})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rotated_x) && $stable(rotated_y)
            && $stable(rotated_z) && $stable(saturated_flag))
        else $error("result beat changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result beat without an accepted vertex");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(MAX_INFLIGHT))
        else $error("more vertices in flight than the datapath holds");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> inflight_reg >= CNT_W'(QUEUE_DEPTH))
        else $error("input stalled with queue not full");

endmodule

bind vertex_rotate_about_pivot vrp_checker u_vrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rotated_x      (rotated_x),
    .rotated_y      (rotated_y),
    .rotated_z      (rotated_z),
    .saturated_flag (saturated_flag)
);
